>>> rtl/ucd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucd_pkg: shared types, constants and helpers of the code detector
// Sizes, register indexes, result codes and the pattern compare functions.
// ----------------------------------------------------------------------------
package ucd_pkg;

    // Block sizes
    localparam int ENTRIES       = 3;
    localparam int CAPTURE_BYTES = 256;
    localparam int PATTERN_BYTES = 8;

    localparam int COUNT_W     = $clog2(CAPTURE_BYTES + 1);
    localparam int TICK_W      = 17;
    localparam int TIMEOUT_W   = 16;
    localparam int CFG_W       = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int FILL_W      = 4;
    localparam int LENGTH_W    = 9;
    localparam int ENTRY_REGS  = 3;

    localparam logic [FILL_W-1:0]    PATTERN_FILL  = FILL_W'(PATTERN_BYTES);
    localparam logic [COUNT_W-1:0]   CAPTURE_LIMIT = COUNT_W'(CAPTURE_BYTES);
    localparam logic [TICK_W-1:0]    TICK_MAX      = {TICK_W{1'b1}};
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

    // Characters and the default terminator
    localparam logic [7:0]  CHAR_CR      = 8'h0D;
    localparam logic [7:0]  CHAR_LF      = 8'h0A;
    localparam logic [63:0] CRLF_PATTERN = 64'h0000_0000_0000_0A0D;
    localparam logic [FILL_W-1:0] CRLF_LENGTH = 4'd2;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PREFIX_A = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PREFIX_B = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PREFIX_C = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SUFFIX_A = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SUFFIX_B = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SUFFIX_C = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT  = 3'd6;

    // Input actions and result kinds
    localparam logic ACTION_BYTE = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_ABORT    = 2'd2;

    // Result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QCOUNT_W-1:0] QUEUE_ROOM_LIMIT = QCOUNT_W'(QUEUE_DEPTH - 2);

    typedef struct packed {
        logic [1:0]          kind;
        logic [7:0]          payload_byte;
        logic [1:0]          entry_index;
        logic [LENGTH_W-1:0] payload_length;
        logic                last_of_run;
    } ucd_result_t;

    // Results of one accepted item, zero to two of them
    typedef struct packed {
        logic [1:0]  count;
        ucd_result_t first;
        ucd_result_t second;
    } ucd_push_t;

    function automatic logic [7:0] byte_at(input logic [63:0] v, input logic [2:0] pos);
        byte_at = v[{pos, 3'b000} +: 8];
    endfunction

    // Count leading nonzero bytes, capped at the pattern size
    function automatic logic [FILL_W-1:0] pattern_length(input logic [63:0] p);
        logic [FILL_W-1:0] n;
        logic              stop;
        n    = '0;
        stop = 1'b0;
        for (int i = 0; i < PATTERN_BYTES; i++)
        begin
            if (!stop && (p[i*8 +: 8] != 8'h00))
                n = n + 1'b1;
            else
                stop = 1'b1;
        end
        pattern_length = n;
    endfunction

    // Newest n bytes of the history equal the n chars of the pattern
    function automatic logic tail_match(input logic [63:0] hist,
                                        input logic [FILL_W-1:0] fill,
                                        input logic [63:0] pat,
                                        input logic [FILL_W-1:0] n);
        logic              ok;
        logic [FILL_W-1:0] pos;
        ok = (n != '0) && (fill >= n);
        for (int i = 0; i < PATTERN_BYTES; i++)
        begin
            pos = n - 1'b1 - FILL_W'(i);
            if ((FILL_W'(i) < n) && (pat[i*8 +: 8] != byte_at(hist, pos[2:0])))
                ok = 1'b0;
        end
        tail_match = ok;
    endfunction

endpackage

>>> rtl/ucd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucd_front: line tracking, prefix match and capture control
// Holds config and line state, handles one item per cycle unless stalled, and
// hands zero to two results per item to the result queue.
// ----------------------------------------------------------------------------
module ucd_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [ucd_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [ucd_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                  in_fire,
    input  logic                                  action,
    input  logic [7:0]                            rx_byte,
    output ucd_pkg::ucd_push_t                    push
);
    import ucd_pkg::*;

    logic [63:0]          prefix_reg [ENTRY_REGS];
    logic [63:0]          suffix_reg [ENTRY_REGS];
    logic [TIMEOUT_W-1:0] timeout_reg;

    logic [63:0]        recent_reg,   recent_next;
    logic [FILL_W-1:0]  fill_reg,     fill_next;
    logic               capturing_reg, capturing_next;
    logic [1:0]         entry_reg,    entry_next;
    logic [COUNT_W-1:0] count_reg,    count_next;
    logic [TICK_W-1:0]  ticks_reg,    ticks_next;

    // Idle-side signals
    logic [63:0]        idle_base;
    logic [FILL_W-1:0]  idle_base_fill;
    logic [63:0]        idle_hist;
    logic [FILL_W-1:0]  idle_fill;
    logic               idle_hit;
    logic [1:0]         idle_entry;
    logic               idle_crlf;

    // Capture-side signals
    logic               overflow;
    logic [63:0]        suffix_raw;
    logic [FILL_W-1:0]  suffix_raw_len;
    logic [63:0]        suffix_pat;
    logic [FILL_W-1:0]  term_len;
    logic               have_exit;
    logic [FILL_W-1:0]  exit_pos;
    logic [7:0]         exit_byte;
    logic [63:0]        cap_hist;
    logic [COUNT_W-1:0] cap_count;
    logic               cap_done;
    logic               timed_out;

    ucd_result_t payload_res, complete_res, abort_res;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRY_REGS; i++)
            begin
                prefix_reg[i] <= '0;
                suffix_reg[i] <= '0;
            end
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_PREFIX_A: prefix_reg[0] <= cfg_data;
                REG_PREFIX_B: prefix_reg[1] <= cfg_data;
                REG_PREFIX_C: prefix_reg[2] <= cfg_data;
                REG_SUFFIX_A: suffix_reg[0] <= cfg_data;
                REG_SUFFIX_B: suffix_reg[1] <= cfg_data;
                REG_SUFFIX_C: suffix_reg[2] <= cfg_data;
                REG_TIMEOUT:  timeout_reg   <= cfg_data[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // Idle path: shift the byte into the line and check prefixes in table order
    always_comb
    begin
        idle_base      = capturing_reg ? 64'd0 : recent_reg;
        idle_base_fill = capturing_reg ? '0 : fill_reg;
        idle_hist      = {idle_base[55:0], rx_byte};
        idle_fill      = (idle_base_fill < PATTERN_FILL) ? idle_base_fill + 1'b1
                                                         : idle_base_fill;
        idle_hit   = 1'b0;
        idle_entry = 2'd0;
        for (int e = ENTRIES - 1; e >= 0; e--)
        begin
            if (tail_match(idle_hist, idle_fill, prefix_reg[e],
                           pattern_length(prefix_reg[e])))
            begin
                idle_hit   = 1'b1;
                idle_entry = 2'(e);
            end
        end
        idle_crlf = (rx_byte == CHAR_LF) && (idle_fill >= 4'd2)
                    && (byte_at(idle_hist, 3'd1) == CHAR_CR);
    end

    // Capture path: delay line exit, terminator check and timeout
    always_comb
    begin
        overflow       = count_reg >= CAPTURE_LIMIT;
        suffix_raw     = suffix_reg[entry_reg];
        suffix_raw_len = pattern_length(suffix_raw);
        if (suffix_raw_len == '0)
        begin
            suffix_pat = CRLF_PATTERN;
            term_len   = CRLF_LENGTH;
        end
        else
        begin
            suffix_pat = suffix_raw;
            term_len   = suffix_raw_len;
        end
        have_exit = count_reg >= COUNT_W'(term_len);
        exit_pos  = term_len - 1'b1;
        exit_byte = byte_at(recent_reg, exit_pos[2:0]);
        cap_hist  = {recent_reg[55:0], rx_byte};
        cap_count = count_reg + 1'b1;
        cap_done  = (term_len != '0) && (cap_count >= COUNT_W'(term_len))
                    && tail_match(cap_hist, PATTERN_FILL, suffix_pat, term_len);
        timed_out = ticks_reg > TICK_W'(timeout_reg);
    end

    // Result templates
    always_comb
    begin
        payload_res                = '0;
        payload_res.kind           = KIND_PAYLOAD;
        payload_res.payload_byte   = exit_byte;
        payload_res.entry_index    = entry_reg;

        complete_res                = '0;
        complete_res.kind           = KIND_COMPLETE;
        complete_res.entry_index    = entry_reg;
        complete_res.payload_length = LENGTH_W'(cap_count - COUNT_W'(term_len));

        abort_res             = '0;
        abort_res.kind        = KIND_ABORT;
        abort_res.entry_index = entry_reg;
    end

    // Next state and results of the transfer
    always_comb
    begin
        recent_next    = recent_reg;
        fill_next      = fill_reg;
        capturing_next = capturing_reg;
        entry_next     = entry_reg;
        count_next     = count_reg;
        ticks_next     = ticks_reg;
        push           = '0;

        if (in_fire)
        begin
            if (action == ACTION_TICK)
            begin
                if (capturing_reg && (ticks_reg != TICK_MAX))
                    ticks_next = ticks_reg + 1'b1;
            end
            else if (!capturing_reg || overflow)
            begin
                if (capturing_reg)
                begin
                    push.count              = 2'd1;
                    push.first              = abort_res;
                    push.first.last_of_run  = 1'b1;
                end
                count_next = '0;
                ticks_next = '0;
                if (idle_hit)
                begin
                    capturing_next = 1'b1;
                    entry_next     = idle_entry;
                    recent_next    = '0;
                    fill_next      = '0;
                end
                else
                begin
                    capturing_next = 1'b0;
                    recent_next    = idle_hist;
                    fill_next      = idle_crlf ? '0 : idle_fill;
                end
            end
            else
            begin
                recent_next = cap_hist;
                count_next  = cap_count;
                if (cap_done)
                begin
                    if (have_exit)
                    begin
                        push.count  = 2'd2;
                        push.first  = payload_res;
                        push.second = complete_res;
                        push.second.last_of_run = 1'b1;
                    end
                    else
                    begin
                        push.count = 2'd1;
                        push.first = complete_res;
                        push.first.last_of_run = 1'b1;
                    end
                end
                else if (timed_out)
                begin
                    push.count = 2'd1;
                    push.first = abort_res;
                    push.first.last_of_run = 1'b1;
                end
                else if (have_exit)
                begin
                    push.count = 2'd1;
                    push.first = payload_res;
                    push.first.last_of_run = 1'b1;
                end
                // Drop back to an empty idle line on completion or timeout
                if (cap_done || timed_out)
                begin
                    capturing_next = 1'b0;
                    recent_next    = '0;
                    fill_next      = '0;
                    count_next     = '0;
                    ticks_next     = '0;
                end
            end
        end
    end

    // Line and capture state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg    <= '0;
            fill_reg      <= '0;
            capturing_reg <= 1'b0;
            entry_reg     <= '0;
            count_reg     <= '0;
            ticks_reg     <= '0;
        end
        else
        begin
            recent_reg    <= recent_next;
            fill_reg      <= fill_next;
            capturing_reg <= capturing_next;
            entry_reg     <= entry_next;
            count_reg     <= count_next;
            ticks_reg     <= ticks_next;
        end
    end

endmodule

>>> rtl/ucd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucd_queue: result queue between front and output channel
// Shifting register queue: up to two writes per cycle, head always at slot 0.
// ----------------------------------------------------------------------------
module ucd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ucd_pkg::ucd_push_t   push,
    input  logic                 pop,
    output ucd_pkg::ucd_result_t head,
    output logic                 not_empty,
    output logic                 room
);
    import ucd_pkg::*;

    ucd_result_t          slot_reg  [QUEUE_DEPTH];
    ucd_result_t          slot_next [QUEUE_DEPTH];
    logic [QCOUNT_W-1:0]  count_reg, count_next;
    logic [QCOUNT_W-1:0]  count_popped;

    // Shift out the head on a transfer, then append new results
    always_comb
    begin
        count_popped = count_reg - QCOUNT_W'(pop);
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (pop && (i < QUEUE_DEPTH - 1))
                slot_next[i] = slot_reg[(i + 1) % QUEUE_DEPTH];
            else
                slot_next[i] = slot_reg[i];
            if ((push.count != 2'd0) && (count_popped == QCOUNT_W'(i)))
                slot_next[i] = push.first;
            if ((push.count == 2'd2) && ((count_popped + 1'b1) == QCOUNT_W'(i)))
                slot_next[i] = push.second;
        end
        count_next = count_popped + QCOUNT_W'(push.count);
    end

    // Hold results
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
            slot_reg[i] <= slot_next[i];
    end

    // Track fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign head      = slot_reg[0];
    assign not_empty = count_reg != '0;
    assign room      = count_reg <= QUEUE_ROOM_LIMIT;

endmodule

>>> rtl/unsolicited_code_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsolicited_code_detector: unsolicited result code detector, top level
// Front handles line tracking and capture; a four-entry result queue feeds
// the output channel so each side can stall on its own.
// ----------------------------------------------------------------------------
// An item's results are registered into the queue and offered after earlier ones.
// Throughput: one item per cycle while in_stall is low; the front has no busy state
// and the output drains one result per cycle from the queue head while not stalled.
// Input stalls while the queue holds more than two results.
// Reset clears line, capture and config state and the queue fill (timeout 1000).
module unsolicited_code_detector (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [ucd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ucd_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             action,
    input  logic [7:0]                       rx_byte,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       kind,
    output logic [7:0]                       payload_byte,
    output logic [1:0]                       entry_index,
    output logic [ucd_pkg::LENGTH_W-1:0]     payload_length,
    output logic                             last_of_run
);
    import ucd_pkg::*;

    ucd_push_t   push;
    ucd_result_t head;
    logic        in_fire;
    logic        out_fire;
    logic        room;

    assign in_stall = !room;
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;

    ucd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_fire      (in_fire),
        .action       (action),
        .rx_byte      (rx_byte),
        .push         (push)
    );

    ucd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (out_fire),
        .head      (head),
        .not_empty (out_valid),
        .room      (room)
    );

    // Drive result fields from the queue head
    assign kind           = head.kind;
    assign payload_byte   = head.payload_byte;
    assign entry_index    = head.entry_index;
    assign payload_length = head.payload_length;
    assign last_of_run    = head.last_of_run;

endmodule
